// ===== rtl/core/dlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsm_pkg: shared types and constants of the DHCP lease state machine
// Phase codes, message type codes, reset values and the item structs.
// ----------------------------------------------------------------------------
package dlsm_pkg;

	typedef enum logic [2:0] {
		PH_PORT_WAIT  = 3'd0,
		PH_INIT       = 3'd1,
		PH_SELECTING  = 3'd2,
		PH_REQUESTING = 3'd3,
		PH_BOUND      = 3'd4
	} phase_t;

	localparam logic [7:0] MSG_NONE     = 8'd0;
	localparam logic [7:0] MSG_DISCOVER = 8'd1;
	localparam logic [7:0] MSG_OFFER    = 8'd2;
	localparam logic [7:0] MSG_REQUEST  = 8'd3;
	localparam logic [7:0] MSG_ACK      = 8'd5;

	localparam logic [31:0] RANDOM_SEED   = 32'h34aa_d34b;
	localparam logic [31:0] INITIAL_DELAY = 32'd100;
	localparam logic [31:0] TIMEOUT_RESET = 32'd781250000;
	localparam int unsigned RandShift     = 3;

	// Register map: byte address 4*index, index taken from paddr[2]
	localparam int unsigned APB_ADDR_W  = 3;
	localparam logic        REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic        port_open_valid;
		logic        reply_valid;
		logic [31:0] reply_identifier;
		logic [7:0]  reply_type;
		logic [31:0] reply_offered_ip;
		logic        dhcp_enable;
		logic [31:0] static_ip;
	} in_item_t;

	typedef struct packed {
		logic [31:0] ip_address;
		logic        request_valid;
		logic [31:0] request_identifier;
		logic [7:0]  request_type;
		logic [31:0] request_ip;
		logic        reply_taken;
		logic        port_open_taken;
	} out_item_t;

endpackage

// ===== rtl/core/dlsm_stream_if.sv =====
// ----------------------------------------------------------------------------
// dlsm_stream_if: valid/ready channel
// Carries one payload beat per cycle in which valid and ready are both high.
// ----------------------------------------------------------------------------
interface dlsm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/dlsm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// dlsm_apb_regs: configuration register file
// Holds the negotiation timeout, written and read over an APB-style port.
// ----------------------------------------------------------------------------
module dlsm_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dlsm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [31:0]                      timeout_ticks
);

	logic [31:0] timeout_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= dlsm_pkg::TIMEOUT_RESET;
		end else if (wr_en && paddr[2] == dlsm_pkg::REG_TIMEOUT) begin
			timeout_q <= pwdata;
		end
	end

	always_comb begin
		case (paddr[2])
			dlsm_pkg::REG_TIMEOUT: prdata = timeout_q;
			default:               prdata = 32'd0;
		endcase
	end

	assign timeout_ticks = timeout_q;

endmodule

// ===== rtl/core/dlsm_fsm.sv =====
// ----------------------------------------------------------------------------
// dlsm_fsm: lease state machine
// Holds phase, identifiers, addresses and the countdown; works out one tick's
// result and updates the state when the tick moves on to the result register.
// ----------------------------------------------------------------------------
module dlsm_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  dlsm_pkg::in_item_t   item,
	input  logic [31:0]          timeout_ticks,
	output dlsm_pkg::out_item_t  res
);

	dlsm_pkg::phase_t phase_q, phase_d;
	logic [31:0] random_q, random_d;
	logic [31:0] xid_q, xid_d;
	logic [31:0] current_ip_q, current_ip_d;
	logic [31:0] offered_ip_q, offered_ip_d;
	logic [31:0] countdown_q, countdown_d;
	logic        discover;
	logic        id_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= dlsm_pkg::PH_PORT_WAIT;
			random_q     <= dlsm_pkg::RANDOM_SEED;
			xid_q        <= 32'd0;
			current_ip_q <= 32'd0;
			offered_ip_q <= 32'd0;
			countdown_q  <= dlsm_pkg::INITIAL_DELAY;
		end else if (step) begin
			phase_q      <= phase_d;
			random_q     <= random_d;
			xid_q        <= xid_d;
			current_ip_q <= current_ip_d;
			offered_ip_q <= offered_ip_d;
			countdown_q  <= countdown_d;
		end
	end

	assign id_match = item.reply_identifier == xid_q;

	always_comb begin
		phase_d      = phase_q;
		xid_d        = xid_q;
		current_ip_d = current_ip_q;
		offered_ip_d = offered_ip_q;
		countdown_d  = countdown_q;
		discover     = 1'b0;

		res                    = '0;
		res.ip_address         = current_ip_q;
		res.request_type       = dlsm_pkg::MSG_NONE;

		case (phase_q)
			dlsm_pkg::PH_INIT: begin
				current_ip_d = item.static_ip;
				if (item.dhcp_enable) begin
					if (countdown_q == 32'd0) begin
						discover               = 1'b1;
						xid_d                  = random_q;
						res.request_valid      = 1'b1;
						res.request_identifier = random_q;
						res.request_type       = dlsm_pkg::MSG_DISCOVER;
						countdown_d            = timeout_ticks;
						phase_d                = dlsm_pkg::PH_SELECTING;
					end else begin
						countdown_d = countdown_q - 32'd1;
					end
				end
			end
			dlsm_pkg::PH_SELECTING, dlsm_pkg::PH_REQUESTING: begin
				if (item.reply_valid) begin
					res.reply_taken = 1'b1;
					// foreign identifiers are swallowed without touching the countdown
					if (id_match) begin
						if (phase_q == dlsm_pkg::PH_SELECTING
								&& item.reply_type == dlsm_pkg::MSG_OFFER) begin
							offered_ip_d           = item.reply_offered_ip;
							res.request_valid      = 1'b1;
							res.request_identifier = xid_q;
							res.request_type       = dlsm_pkg::MSG_REQUEST;
							res.request_ip         = item.reply_offered_ip;
							countdown_d            = timeout_ticks;
							phase_d                = dlsm_pkg::PH_REQUESTING;
						end else if (phase_q == dlsm_pkg::PH_REQUESTING
								&& item.reply_type == dlsm_pkg::MSG_ACK) begin
							current_ip_d = offered_ip_q;
							phase_d      = dlsm_pkg::PH_BOUND;
						end else begin
							phase_d = dlsm_pkg::PH_INIT;
						end
					end
				end else if (countdown_q == 32'd0) begin
					phase_d = dlsm_pkg::PH_INIT;
				end else begin
					countdown_d = countdown_q - 32'd1;
				end
			end
			dlsm_pkg::PH_BOUND: begin
				res.reply_taken = item.reply_valid;
				if (!item.dhcp_enable) begin
					phase_d = dlsm_pkg::PH_INIT;
				end
			end
			default: begin
				phase_d      = dlsm_pkg::PH_PORT_WAIT;
				current_ip_d = item.static_ip;
				if (item.port_open_valid) begin
					res.port_open_taken = 1'b1;
					phase_d             = dlsm_pkg::PH_INIT;
				end
			end
		endcase

		// xorshift scramble on a discover, then the per-tick increment
		random_d = (discover ? ((random_q << dlsm_pkg::RandShift) ^ random_q) : random_q)
			+ 32'd1;
	end

endmodule

// ===== rtl/core/dhcp_lease_state_machine_top.sv =====
// ----------------------------------------------------------------------------
// dhcp_lease_state_machine_top: DHCP client lease state machine
// Input register, lease state machine and result register with APB config.
// ----------------------------------------------------------------------------
// Usage:
//   item   - one beat per clock tick: port-open notice, parsed reply, enable
//            level and fallback address.
//   result - one beat per item: address held before the tick, the discover or
//            request issued (if any) and the reply / port-notice consumption.
//   APB    - register 0 at byte address 0: timeout_ticks (offer/ack wait).
// Path: an accepted beat is registered in the input register; when the machine
// steps on it, its result is registered and shown on the result channel.
// Throughput: one beat per cycle while the result channel does not stall; the state
// update of one beat is a single pass through the state machine logic between the
// input and result register. Reset puts the machine in port wait with the initial
// delay countdown at 100, the identifier seed loaded and the timeout at its default.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that item.ready drops until the
// result is taken.
// ----------------------------------------------------------------------------
module dhcp_lease_state_machine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	dlsm_stream_if.sink                     item,
	dlsm_stream_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dlsm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	dlsm_pkg::in_item_t  item_s1;
	logic                valid_s1;
	dlsm_pkg::out_item_t result_s2;
	logic                valid_s2;
	dlsm_pkg::out_item_t res;
	logic [31:0]         timeout_ticks;
	logic                advance;

	dlsm_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	dlsm_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.timeout_ticks (timeout_ticks),
		.res           (res)
	);

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			valid_s2 <= advance || (valid_s2 && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("state step without a registered result");

	a_request_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.request_valid) |->
			(result_s2.request_type == dlsm_pkg::MSG_DISCOVER
			|| result_s2.request_type == dlsm_pkg::MSG_REQUEST))
		else $error("issued message with an unexpected type code");

	a_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.reply_taken && result_s2.port_open_taken))
		else $error("reply and port notice consumed in the same tick");

endmodule
